/* sv/srld_pkg.sv */
// Shared types, constants and the gradient step table for the sprite line decoder.
// No dependencies; every other file but srld_if refers to it by scoped names.
package srld_pkg;

  localparam int HIST_DEPTH     = 1024;
  localparam int HIST_AW        = 10;
  localparam int HIST_FW        = 11;
  localparam int MAX_LINE_WIDTH = 320;
  localparam int PEN_CAP        = 1023;
  localparam int LW_RESET       = 320;

  // Record parse phases
  typedef enum logic [3:0] {
    PH_LENGTH, PH_COLUMN, PH_CONTROL, PH_LITERAL, PH_FILL,
    PH_OFS_LOW, PH_OFS_HIGH, PH_PAIR_A, PH_PAIR_B, PH_GRADIENT
  } phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    K_PIXELS = 2'd0,
    K_LINE   = 2'd1,
    K_SKIP   = 2'd2,
    K_ERROR  = 2'd3
  } kind_t;

  // Control byte opcodes
  localparam logic [2:0] OP_LIT0 = 3'd0;
  localparam logic [2:0] OP_LIT1 = 3'd1;
  localparam logic [2:0] OP_FILL = 3'd2;
  localparam logic [2:0] OP_COPY = 3'd3;
  localparam logic [2:0] OP_PAIR = 3'd4;
  localparam logic [2:0] OP_ZERO = 3'd5;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_READ, S_PAIR, S_LINE, S_SINGLE
  } state_t;

  typedef struct packed {
    logic accept;
    logic decode;
    logic rd;
    logic emit_pair;
    logic emit_line;
    logic emit_single;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic run;
    logic copy;
    logic line;
    logic single;
    logic run_last;
    logic line_pend;
    logic copy_pend;
  } sts_t;

  // Gradient colour steps, negative steps held mod 256
  function automatic logic [7:0] grad_step(input logic [3:0] idx);
    logic [7:0] s;
    unique case (idx)
      4'd0, 4'd8:            s = 8'd0;
      4'd1, 4'd2, 4'd3:      s = 8'd1;
      4'd4, 4'd5:            s = 8'd2;
      4'd6, 4'd7:            s = 8'd3;
      4'd9, 4'd10, 4'd11:    s = 8'd255;
      4'd12, 4'd13:          s = 8'd254;
      default:               s = 8'd253;
    endcase
    return s;
  endfunction

endpackage

/* sv/srld_if.sv */
// Word channel interfaces for the sprite line decoder: byte input and result output.
// Depends on nothing.
interface srld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;
  modport source (output valid, data_byte, restart, input ready);
  modport sink   (input valid, data_byte, restart, output ready);
endinterface

interface srld_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [8:0] column;
  logic [7:0] first_pixel;
  logic [7:0] second_pixel;
  logic [1:0] pixel_count;
  logic [8:0] line_count;
  logic       overflow;
  logic       last;
  modport source (output valid, kind, column, first_pixel, second_pixel, pixel_count,
                  line_count, overflow, last, input ready);
  modport sink   (input valid, kind, column, first_pixel, second_pixel, pixel_count,
                  line_count, overflow, last, output ready);
endinterface

/* sv/sprite_line_run_decoder.sv */
// Sprite line decoder: each byte word is accepted, then decoded; a byte that yields
// pixels then emits them a pair at a time as the output slot frees (a history
// copy reads the history RAM once per pair), and a line, skip or error word is
// emitted on its own; the longest run, a pair op, has 66 pixels, the longest copy 35.
// The output word register lets the next byte be taken while the last result
// still waits. The history holds 1024 bytes, needs no clearing pass, and
// survives restart and record ends.
// Depends on srld_pkg, srld_if, srld_ctrl and srld_dp.
module sprite_line_run_decoder (
  input  logic        clk,
  input  logic        rst_n,
  srld_in_if.sink     in_ch,
  srld_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata
);

  srld_pkg::cmd_t cmd;
  srld_pkg::sts_t sts;

  srld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srld_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_data_byte     (in_ch.data_byte),
    .in_restart       (in_ch.restart),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_kind         (out_ch.kind),
    .out_column       (out_ch.column),
    .out_first_pixel  (out_ch.first_pixel),
    .out_second_pixel (out_ch.second_pixel),
    .out_pixel_count  (out_ch.pixel_count),
    .out_line_count   (out_ch.line_count),
    .out_overflow     (out_ch.overflow),
    .out_last         (out_ch.last)
  );

  // An accepted word is decoded before the next is taken
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("word accepted while the previous one is still decoding");

  // Non-pixel words carry no pixels
  a_no_pix: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind != srld_pkg::K_PIXELS |-> out_ch.pixel_count == 2'd0)
    else $error("non-pixel word carries pixels");

  // Pixel words carry one or two pixels inside the line
  a_pix_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == srld_pkg::K_PIXELS |->
      out_ch.pixel_count != 2'd0 && out_ch.pixel_count != 2'd3 &&
      out_ch.column < 9'(srld_pkg::MAX_LINE_WIDTH))
    else $error("pixel word out of range");

endmodule

/* sv/srld_ctrl.sv */
// Sequencer for the sprite line decoder: accepts a word, decodes it, then steps
// through pixel pairs, history reads, line and single results. Depends on srld_pkg.
module srld_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  srld_pkg::sts_t sts,
  output srld_pkg::cmd_t cmd
);

  srld_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= srld_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      srld_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_nxt = srld_pkg::S_DECODE;
      end
      srld_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.run)         state_nxt = sts.copy ? srld_pkg::S_READ : srld_pkg::S_PAIR;
        else if (sts.line)   state_nxt = srld_pkg::S_LINE;
        else if (sts.single) state_nxt = srld_pkg::S_SINGLE;
        else                 state_nxt = srld_pkg::S_IDLE;
      end
      srld_pkg::S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = srld_pkg::S_PAIR;
      end
      srld_pkg::S_PAIR: begin
        if (sts.slot_free) begin
          cmd.emit_pair = 1'b1;
          if (sts.run_last)
            state_nxt = sts.line_pend ? srld_pkg::S_LINE : srld_pkg::S_IDLE;
          else
            state_nxt = sts.copy_pend ? srld_pkg::S_READ : srld_pkg::S_PAIR;
        end
      end
      srld_pkg::S_LINE: begin
        if (sts.slot_free) begin
          cmd.emit_line = 1'b1;
          state_nxt     = srld_pkg::S_IDLE;
        end
      end
      srld_pkg::S_SINGLE: begin
        if (sts.slot_free) begin
          cmd.emit_single = 1'b1;
          state_nxt       = srld_pkg::S_IDLE;
        end
      end
      default: state_nxt = srld_pkg::S_IDLE;
    endcase
  end

endmodule

/* sv/srld_dp.sv */
// Datapath for the sprite line decoder: record parse state, history ring memory,
// pair generator and the output word register. Depends on srld_pkg.
module srld_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  srld_pkg::cmd_t cmd,
  output srld_pkg::sts_t sts,
  input  logic [7:0]     in_data_byte,
  input  logic           in_restart,
  input  logic           cfg_we,
  input  logic [8:0]     cfg_wdata,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [1:0]     out_kind,
  output logic [8:0]     out_column,
  output logic [7:0]     out_first_pixel,
  output logic [7:0]     out_second_pixel,
  output logic [1:0]     out_pixel_count,
  output logic [8:0]     out_line_count,
  output logic           out_overflow,
  output logic           out_last
);

  // Configuration and history
  logic [8:0]                    lw_r;
  logic [7:0]                    hist_mem [srld_pkg::HIST_DEPTH];
  logic [srld_pkg::HIST_AW-1:0]  ptr_r;
  logic [srld_pkg::HIST_FW-1:0]  fill_r;

  // Latched word
  logic [7:0] byte_r;
  logic       rs_r;

  // Parse state
  srld_pkg::phase_t phase_r, ph, ph_nxt;
  logic [7:0] rbl_r, rbl, rbl_nxt;
  logic [9:0] pen_r, pen_nxt;
  logic       wovf_r, wovf_nxt;
  logic [7:0] hc_r, hc_nxt;
  logic [7:0] col_r, col_nxt;
  logic [7:0] ofs_r, ofs_nxt;
  logic [6:0] lit_r, lit_nxt;

  // Run state
  logic [6:0] cnt_r, cnt;
  logic [6:0] i_r;
  logic [7:0] ra_r, rb_r, ra, rb;
  logic [7:0] ss_r, ss;
  logic       copy_r, line_pend_r;
  logic [srld_pkg::HIST_AW-1:0] start_r, start;
  logic [7:0] mem_a_r, mem_b_r;
  logic [1:0] skind_r;
  logic [8:0] slines_r;
  srld_pkg::kind_t skind;
  logic [8:0] slines;

  // Decode intermediates
  logic        run, copy, line, single, endop;
  logic [2:0]  op;
  logic [6:0]  need;
  logic [15:0] back;
  logic [6:0]  clen;
  logic [3:0]  gbase;
  logic [7:0]  s0, s1;

  // Pair intermediates
  logic [10:0] c, psum;
  logic [8:0]  eff_w;
  logic [6:0]  rem;
  logic        k2, fits, fits2, run_last;
  logic [7:0]  pa, pb;
  logic [srld_pkg::HIST_AW-1:0] ra0, ra1;

  // Output register
  logic       ov_r;
  logic [1:0] okind_r, ocnt_r;
  logic [8:0] ocol_r, olines_r;
  logic [7:0] op0_r, op1_r;
  logic       oovf_r, olast_r;
  logic       slot_free;

  assign slot_free = !ov_r || out_ready;
  assign eff_w     = (lw_r > 9'(srld_pkg::MAX_LINE_WIDTH)) ?
                     9'(srld_pkg::MAX_LINE_WIDTH) : lw_r;

  // Decode the latched word against the parse state
  always_comb begin
    ph      = rs_r ? srld_pkg::PH_LENGTH : phase_r;
    rbl     = rbl_r;
    if (ph != srld_pkg::PH_LENGTH && ph != srld_pkg::PH_COLUMN && rbl_r != 8'd0)
      rbl = rbl_r - 8'd1;
    ph_nxt  = ph;
    rbl_nxt = rbl;
    pen_nxt = pen_r;
    wovf_nxt = wovf_r;
    hc_nxt  = hc_r;
    col_nxt = col_r;
    ofs_nxt = ofs_r;
    lit_nxt = lit_r;
    run = 1'b0; copy = 1'b0; line = 1'b0; single = 1'b0; endop = 1'b0;
    skind  = srld_pkg::K_ERROR;
    slines = 9'd0;
    cnt = 7'd0; ra = 8'd0; rb = 8'd0; ss = 8'd0;
    op    = byte_r[7:5];
    need  = 7'd1;
    back  = {byte_r, ofs_r};
    clen  = {2'b00, hc_r[4:0]} + 7'd4;
    gbase = {hc_r[5:3], 1'b0};
    s0    = srld_pkg::grad_step(gbase);
    s1    = srld_pkg::grad_step(gbase | 4'd1);
    start = ptr_r - back[srld_pkg::HIST_AW-1:0];
    unique case (ph)
      srld_pkg::PH_LENGTH: begin
        rbl_nxt = byte_r;
        ph_nxt  = srld_pkg::PH_COLUMN;
      end
      srld_pkg::PH_COLUMN: begin
        if (rbl == 8'd0) begin
          single = 1'b1;
          skind  = srld_pkg::K_SKIP;
          slines = {1'b0, byte_r} + 9'd1;
          ph_nxt = srld_pkg::PH_LENGTH;
        end else begin
          rbl_nxt  = rbl - 8'd1;
          pen_nxt  = {2'b00, byte_r};
          wovf_nxt = 1'b0;
          endop    = 1'b1;
        end
      end
      srld_pkg::PH_CONTROL: begin
        case (op)
          srld_pkg::OP_LIT0, srld_pkg::OP_LIT1: need = {1'b0, byte_r[5:0]} + 7'd1;
          srld_pkg::OP_COPY, srld_pkg::OP_PAIR: need = 7'd2;
          srld_pkg::OP_ZERO:                    need = 7'd0;
          default:                              need = 7'd1;
        endcase
        if ({1'b0, need} > rbl) begin
          single = 1'b1;
          ph_nxt = srld_pkg::PH_LENGTH;
        end else begin
          hc_nxt = byte_r;
          case (op)
            srld_pkg::OP_LIT0, srld_pkg::OP_LIT1: begin
              lit_nxt = need;
              ph_nxt  = srld_pkg::PH_LITERAL;
            end
            srld_pkg::OP_FILL: ph_nxt = srld_pkg::PH_FILL;
            srld_pkg::OP_COPY: ph_nxt = srld_pkg::PH_OFS_LOW;
            srld_pkg::OP_PAIR: ph_nxt = srld_pkg::PH_PAIR_A;
            srld_pkg::OP_ZERO: begin
              run   = 1'b1;
              cnt   = {2'b00, byte_r[4:0]} + 7'd1;
              endop = 1'b1;
            end
            default: ph_nxt = srld_pkg::PH_GRADIENT;
          endcase
        end
      end
      srld_pkg::PH_LITERAL: begin
        run = 1'b1;
        cnt = 7'd1;
        ra  = byte_r;
        if (lit_r != 7'd0) lit_nxt = lit_r - 7'd1;
        if (lit_nxt == 7'd0) endop = 1'b1;
      end
      srld_pkg::PH_FILL: begin
        run   = 1'b1;
        cnt   = {2'b00, hc_r[4:0]} + 7'd3;
        ra    = byte_r;
        rb    = byte_r;
        endop = 1'b1;
      end
      srld_pkg::PH_OFS_LOW: begin
        ofs_nxt = byte_r;
        ph_nxt  = srld_pkg::PH_OFS_HIGH;
      end
      srld_pkg::PH_OFS_HIGH: begin
        if (back < {9'd0, clen} || back > {5'd0, fill_r}) begin
          single = 1'b1;
          ph_nxt = srld_pkg::PH_LENGTH;
        end else begin
          run   = 1'b1;
          copy  = 1'b1;
          cnt   = clen;
          endop = 1'b1;
        end
      end
      srld_pkg::PH_PAIR_A: begin
        col_nxt = byte_r;
        ph_nxt  = srld_pkg::PH_PAIR_B;
      end
      srld_pkg::PH_PAIR_B: begin
        run   = 1'b1;
        cnt   = {({1'b0, hc_r[4:0]} + 6'd2), 1'b0};
        ra    = col_r;
        rb    = byte_r;
        endop = 1'b1;
      end
      srld_pkg::PH_GRADIENT: begin
        run   = 1'b1;
        cnt   = {4'd0, hc_r[2:0]} + 7'd3;
        ra    = byte_r;
        rb    = byte_r + s0;
        ss    = s0 + s1;
        endop = 1'b1;
      end
      default: ph_nxt = srld_pkg::PH_LENGTH;
    endcase
    // Finish the op: close the line or wait for the next control byte
    if (endop) begin
      if (rbl_nxt == 8'd0) begin
        line   = 1'b1;
        ph_nxt = srld_pkg::PH_LENGTH;
      end else begin
        ph_nxt = srld_pkg::PH_CONTROL;
      end
    end
  end

  // Current pair against the line width
  always_comb begin
    c        = {1'b0, pen_r} + {4'd0, i_r};
    rem      = cnt_r - i_r;
    k2       = rem >= 7'd2;
    fits     = c < {2'b00, eff_w};
    fits2    = (c + 11'd1) < {2'b00, eff_w};
    run_last = ({1'b0, i_r} + 8'd2) >= {1'b0, cnt_r};
    psum     = {1'b0, pen_r} + {4'd0, cnt_r};
    pa       = copy_r ? mem_a_r : ra_r;
    pb       = copy_r ? mem_b_r : rb_r;
    ra0      = start_r + srld_pkg::HIST_AW'(i_r);
    ra1      = ra0 + 1'b1;
  end

  always_comb begin
    sts.slot_free = slot_free;
    sts.run       = run;
    sts.copy      = copy;
    sts.line      = line && !run;
    sts.single    = single;
    sts.run_last  = run_last;
    sts.line_pend = line_pend_r;
    sts.copy_pend = copy_r;
  end

  // History ring: write each accepted word, read two bytes per copied pair
  always_ff @(posedge clk) begin
    if (cmd.accept) hist_mem[ptr_r] <= in_data_byte;
    if (cmd.rd) begin
      mem_a_r <= hist_mem[ra0];
      mem_b_r <= hist_mem[ra1];
    end
  end

  // Control state: width, history pointers, parse phase and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r    <= 9'(srld_pkg::LW_RESET);
      ptr_r   <= '0;
      fill_r  <= '0;
      phase_r <= srld_pkg::PH_LENGTH;
      rbl_r   <= '0;
      pen_r   <= '0;
      wovf_r  <= 1'b0;
      hc_r    <= '0;
      col_r   <= '0;
      ofs_r   <= '0;
      lit_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_we) lw_r <= cfg_wdata;
      if (cmd.accept) begin
        ptr_r <= ptr_r + 1'b1;
        if (fill_r < srld_pkg::HIST_FW'(srld_pkg::HIST_DEPTH)) fill_r <= fill_r + 1'b1;
      end
      if (cmd.decode) begin
        phase_r <= ph_nxt;
        rbl_r   <= rbl_nxt;
        pen_r   <= pen_nxt;
        wovf_r  <= wovf_nxt;
        hc_r    <= hc_nxt;
        col_r   <= col_nxt;
        ofs_r   <= ofs_nxt;
        lit_r   <= lit_nxt;
      end
      if (cmd.emit_pair) begin
        if (!fits || (k2 && !fits2)) wovf_r <= 1'b1;
        if (run_last)
          pen_r <= (psum > 11'(srld_pkg::PEN_CAP)) ? 10'(srld_pkg::PEN_CAP) : psum[9:0];
      end
      // Hold the output word until taken
      if (cmd.emit_line || cmd.emit_single || (cmd.emit_pair && fits)) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  // Run payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_data_byte;
      rs_r   <= in_restart;
    end
    if (cmd.decode) begin
      cnt_r       <= cnt;
      i_r         <= 7'd0;
      ra_r        <= ra;
      rb_r        <= rb;
      ss_r        <= ss;
      copy_r      <= copy;
      line_pend_r <= line;
      start_r     <= start;
      skind_r     <= skind;
      slines_r    <= slines;
    end
    if (cmd.emit_pair) begin
      i_r  <= i_r + 7'd2;
      ra_r <= ra_r + ss_r;
      rb_r <= rb_r + ss_r;
    end
  end

  // Output word payload
  always_ff @(posedge clk) begin
    if (cmd.emit_pair && fits) begin
      okind_r  <= srld_pkg::K_PIXELS;
      ocol_r   <= c[8:0];
      op0_r    <= pa;
      op1_r    <= (k2 && fits2) ? pb : 8'd0;
      ocnt_r   <= (k2 && fits2) ? 2'd2 : 2'd1;
      olines_r <= 9'd0;
      oovf_r   <= 1'b0;
      olast_r  <= (run_last || !fits2 || (c + 11'd2) >= {2'b00, eff_w}) && !line_pend_r;
    end else if (cmd.emit_line) begin
      okind_r  <= srld_pkg::K_LINE;
      ocol_r   <= 9'd0;
      op0_r    <= 8'd0;
      op1_r    <= 8'd0;
      ocnt_r   <= 2'd0;
      olines_r <= 9'd1;
      oovf_r   <= wovf_r;
      olast_r  <= 1'b1;
    end else if (cmd.emit_single) begin
      okind_r  <= skind_r;
      ocol_r   <= 9'd0;
      op0_r    <= 8'd0;
      op1_r    <= 8'd0;
      ocnt_r   <= 2'd0;
      olines_r <= slines_r;
      oovf_r   <= 1'b0;
      olast_r  <= 1'b1;
    end
  end

  assign out_valid        = ov_r;
  assign out_kind         = okind_r;
  assign out_column       = ocol_r;
  assign out_first_pixel  = op0_r;
  assign out_second_pixel = op1_r;
  assign out_pixel_count  = ocnt_r;
  assign out_line_count   = olines_r;
  assign out_overflow     = oovf_r;
  assign out_last         = olast_r;

endmodule

/* bench/sprite_line_run_decoder_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for sprite_line_run_decoder: random and directed line records
// with idling on both word channels, checked against a scoreboard predictor.
// Depends on srld_pkg, srld_if and the decoder RTL.
module sprite_line_run_decoder_test;

  typedef struct packed {
    srld_pkg::kind_t kind;
    logic [8:0] column;
    logic [7:0] first_pixel;
    logic [7:0] second_pixel;
    logic [1:0] pixel_count;
    logic [8:0] line_count;
    logic       overflow;
    logic       last;
  } line_word_t;

  // Decoder predictor and store of expected result words
  class line_scoreboard;
    srld_pkg::phase_t phase;
    int         bytes_left, pen, lits_left, fill, ptr, width;
    logic [7:0] ctrl, color, ofs_low;
    logic       wovf;
    logic [7:0] hist [srld_pkg::HIST_DEPTH];
    line_word_t expq [$];
    int         errors;

    function new();
      phase = srld_pkg::PH_LENGTH; bytes_left = 0; pen = 0; lits_left = 0;
      fill = 0; ptr = 0; width = srld_pkg::LW_RESET; ctrl = 0; color = 0; ofs_low = 0;
      wovf = 0; errors = 0;
      foreach (hist[i]) hist[i] = 8'd0;
    endfunction

    function void set_width(int w);
      width = w;
    endfunction

    function int pending();
      return expq.size();
    endfunction

    function void put(srld_pkg::kind_t k, int col, logic [7:0] p0, logic [7:0] p1, int cnt,
                      int lines, logic ovf);
      line_word_t r;
      r.kind = k; r.column = col[8:0]; r.first_pixel = p0; r.second_pixel = p1;
      r.pixel_count = cnt[1:0]; r.line_count = lines[8:0]; r.overflow = ovf;
      r.last = 1'b0;
      expq.push_back(r);
    endfunction

    // Pair pixels from the op's first pixel, drop those past the width
    function void emit_run(logic [7:0] px [80], int cnt);
      int w, c, k;
      w = (width > srld_pkg::MAX_LINE_WIDTH) ? srld_pkg::MAX_LINE_WIDTH : width;
      for (int i = 0; i < cnt; i += 2) begin
        c = pen + i;
        k = (cnt - i >= 2) ? 2 : 1;
        if (c >= w) begin
          wovf = 1'b1;
          continue;
        end
        if (k == 2 && c + 1 >= w) begin
          k = 1;
          wovf = 1'b1;
        end
        put(srld_pkg::K_PIXELS, c, px[i], (k == 2) ? px[i + 1] : 8'd0, k, 0, 1'b0);
      end
      pen += cnt;
      if (pen > srld_pkg::PEN_CAP) pen = srld_pkg::PEN_CAP;
    endfunction

    function void end_op();
      if (bytes_left == 0) begin
        put(srld_pkg::K_LINE, 0, 0, 0, 0, 1, wovf);
        phase = srld_pkg::PH_LENGTH;
      end else begin
        phase = srld_pkg::PH_CONTROL;
      end
    endfunction

    function void fail();
      put(srld_pkg::K_ERROR, 0, 0, 0, 0, 0, 1'b0);
      phase = srld_pkg::PH_LENGTH;
    endfunction

    function void note_byte(logic [7:0] b, logic rs);
      logic [7:0] px [80];
      logic [7:0] gcol;
      logic [2:0] op;
      int         n_prior, len, need, back, start, base;
      n_prior = expq.size();
      // log into the history ring
      hist[ptr] = b;
      ptr = (ptr + 1) % srld_pkg::HIST_DEPTH;
      if (fill < srld_pkg::HIST_DEPTH) fill++;
      if (rs) phase = srld_pkg::PH_LENGTH;
      if (phase != srld_pkg::PH_LENGTH && phase != srld_pkg::PH_COLUMN && bytes_left > 0)
        bytes_left--;
      case (phase)
        srld_pkg::PH_LENGTH: begin
          bytes_left = b;
          phase = srld_pkg::PH_COLUMN;
        end
        srld_pkg::PH_COLUMN: begin
          if (bytes_left == 0) begin
            put(srld_pkg::K_SKIP, 0, 0, 0, 0, b + 1, 1'b0);
            phase = srld_pkg::PH_LENGTH;
          end else begin
            bytes_left--;
            pen = b;
            wovf = 1'b0;
            end_op();
          end
        end
        srld_pkg::PH_CONTROL: begin
          op = b[7:5];
          len = b[4:0];
          if (op == srld_pkg::OP_LIT0 || op == srld_pkg::OP_LIT1) need = b[5:0] + 1;
          else if (op == srld_pkg::OP_COPY || op == srld_pkg::OP_PAIR) need = 2;
          else if (op == srld_pkg::OP_ZERO) need = 0;
          else need = 1;
          if (need > bytes_left) begin
            fail();
          end else begin
            ctrl = b;
            case (op)
              srld_pkg::OP_LIT0, srld_pkg::OP_LIT1: begin
                lits_left = need;
                phase = srld_pkg::PH_LITERAL;
              end
              srld_pkg::OP_FILL: phase = srld_pkg::PH_FILL;
              srld_pkg::OP_COPY: phase = srld_pkg::PH_OFS_LOW;
              srld_pkg::OP_PAIR: phase = srld_pkg::PH_PAIR_A;
              srld_pkg::OP_ZERO: begin
                for (int i = 0; i < 80; i++) px[i] = 8'd0;
                emit_run(px, len + 1);
                end_op();
              end
              default: phase = srld_pkg::PH_GRADIENT;
            endcase
          end
        end
        srld_pkg::PH_LITERAL: begin
          px[0] = b;
          emit_run(px, 1);
          if (lits_left > 0) lits_left--;
          if (lits_left == 0) end_op();
        end
        srld_pkg::PH_FILL: begin
          len = ctrl[4:0] + 3;
          for (int i = 0; i < len; i++) px[i] = b;
          emit_run(px, len);
          end_op();
        end
        srld_pkg::PH_OFS_LOW: begin
          ofs_low = b;
          phase = srld_pkg::PH_OFS_HIGH;
        end
        srld_pkg::PH_OFS_HIGH: begin
          back = {b, ofs_low};
          len = ctrl[4:0] + 4;
          if (back < len || back > fill) begin
            fail();
          end else begin
            start = (ptr + srld_pkg::HIST_DEPTH - back) % srld_pkg::HIST_DEPTH;
            for (int i = 0; i < len; i++)
              px[i] = hist[(start + i) % srld_pkg::HIST_DEPTH];
            emit_run(px, len);
            end_op();
          end
        end
        srld_pkg::PH_PAIR_A: begin
          color = b;
          phase = srld_pkg::PH_PAIR_B;
        end
        srld_pkg::PH_PAIR_B: begin
          len = ctrl[4:0] + 2;
          for (int i = 0; i < len; i++) begin
            px[2 * i] = color;
            px[2 * i + 1] = b;
          end
          emit_run(px, 2 * len);
          end_op();
        end
        srld_pkg::PH_GRADIENT: begin
          base = {ctrl[5:3], 1'b0};
          gcol = b;
          len = ctrl[2:0] + 3;
          for (int i = 0; i < len; i++) begin
            px[i] = gcol;
            gcol = gcol + srld_pkg::grad_step(4'(base + (i & 1)));
          end
          emit_run(px, len);
          end_op();
        end
        default: phase = srld_pkg::PH_LENGTH;
      endcase
      if (expq.size() > n_prior) expq[expq.size() - 1].last = 1'b1;
    endfunction

    function void field(string name, int e, int a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(line_word_t a);
      line_word_t e;
      if (expq.size() == 0) begin
        $display("%0t: unexpected result word, actual %p", $time, a);
        errors++;
        return;
      end
      e = expq.pop_front();
      field("kind", e.kind, a.kind);
      field("column", e.column, a.column);
      field("first_pixel", e.first_pixel, a.first_pixel);
      field("second_pixel", e.second_pixel, a.second_pixel);
      field("pixel_count", e.pixel_count, a.pixel_count);
      field("line_count", e.line_count, a.line_count);
      field("overflow", e.overflow, a.overflow);
      field("last", e.last, a.last);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [8:0] cfg_wdata = 9'd0;
  logic       calm = 1'b0;
  int         sent_total = 0;
  logic [7:0] rec [$];
  line_scoreboard sb;

  srld_in_if  in_ch ();
  srld_out_if out_ch ();

  sprite_line_run_decoder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.restart = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_ch.ready <= rst_n && (calm || $urandom_range(99) >= 34);
  end

  // Check every accepted result word
  always @(posedge clk) begin
    line_word_t a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a.kind = srld_pkg::kind_t'(out_ch.kind);
      a.column = out_ch.column;
      a.first_pixel = out_ch.first_pixel;
      a.second_pixel = out_ch.second_pixel;
      a.pixel_count = out_ch.pixel_count;
      a.line_count = out_ch.line_count;
      a.overflow = out_ch.overflow;
      a.last = out_ch.last;
      sb.check_result(a);
    end
  end

  // Present one byte word, idling first at random
  task automatic send_byte(logic [7:0] b, logic rs);
    if (!calm && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.restart <= rs;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(b, rs);
    sent_total++;
  endtask

  // Send rec; restart on its length byte when mid-record, else at random
  task automatic send_rec();
    logic rs;
    rs = (sb.phase != srld_pkg::PH_LENGTH) ? 1'b1 : 1'($urandom_range(1));
    foreach (rec[i]) send_byte(rec[i], (i == 0) ? rs : 1'b0);
  endtask

  // Build a record of random ops into rec, its length byte set to match
  task automatic build_record();
    int nops, op, n, cnt, fill_at, d;
    rec = {8'd0, 8'($urandom_range(255))};
    if ($urandom_range(9) == 0) return;
    nops = $urandom_range(1, 4);
    for (int j = 0; j < nops && rec.size() < 40; j++) begin
      op = $urandom_range(7);
      n = $urandom_range(31);
      fill_at = sent_total + rec.size() + 3;
      if (fill_at > srld_pkg::HIST_DEPTH) fill_at = srld_pkg::HIST_DEPTH;
      if (op == srld_pkg::OP_COPY && fill_at < n + 4) op = srld_pkg::OP_ZERO;
      case (op)
        srld_pkg::OP_LIT0, srld_pkg::OP_LIT1: begin
          cnt = ($urandom_range(7) == 0) ? 64 : $urandom_range(1, 8);
          rec.push_back(8'(cnt - 1));
          repeat (cnt) rec.push_back(8'($urandom_range(255)));
        end
        srld_pkg::OP_FILL: begin
          rec.push_back({3'(srld_pkg::OP_FILL), 5'(n)});
          rec.push_back(8'($urandom_range(255)));
        end
        srld_pkg::OP_COPY: begin
          // a few distances that reach ahead or out of the window
          case ($urandom_range(9))
            0: d = $urandom_range(0, n + 3);
            1: d = fill_at + $urandom_range(1, 40000);
            default: d = $urandom_range(n + 4, fill_at);
          endcase
          rec.push_back({3'(srld_pkg::OP_COPY), 5'(n)});
          rec.push_back(d[7:0]);
          rec.push_back(d[15:8]);
        end
        srld_pkg::OP_PAIR: begin
          rec.push_back({3'(srld_pkg::OP_PAIR), 5'(n)});
          rec.push_back(8'($urandom_range(255)));
          rec.push_back(8'($urandom_range(255)));
        end
        srld_pkg::OP_ZERO: rec.push_back({3'(srld_pkg::OP_ZERO), 5'(n)});
        default: begin
          rec.push_back({3'(op), 5'(n)});
          rec.push_back(8'($urandom_range(255)));
        end
      endcase
    end
    rec[0] = 8'(rec.size() - 1);
  endtask

  // Random records, with a share of noise, truncations and short lengths
  task automatic random_bytes(int count);
    int stop;
    stop = sent_total + count;
    while (sent_total < stop) begin
      build_record();
      case ($urandom_range(9))
        0: begin
          rec = {};
          repeat ($urandom_range(1, 8)) rec.push_back(8'($urandom_range(255)));
        end
        1: if (rec.size() > 3) rec = rec[0:$urandom_range(1, rec.size() - 2)];
        2: if (rec[0] > 1) rec[0] = 8'($urandom_range(1, rec[0] - 1));
        default: ;
      endcase
      send_rec();
    end
  endtask

  // Let the decoder drain, then write the line width
  task automatic write_width(int w);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= 9'(w);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_width(w);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_width(320);
    // Skips of both extreme line counts, one-byte record
    rec = {8'd0, 8'd0};     send_rec();
    rec = {8'd0, 8'd255};   send_rec();
    rec = {8'd1, 8'd5};     send_rec();
    // Longest literal run
    rec = {8'd66, 8'd0, 8'h3F};
    for (int i = 0; i < 64; i++) rec.push_back(8'(i * 4 + 3));
    send_rec();
    // Longest fill, pair and zero runs
    rec = {8'd3, 8'd250, 8'h5F, 8'hAB};        send_rec();
    rec = {8'd4, 8'd0, 8'h9F, 8'h01, 8'hFE};   send_rec();
    rec = {8'd2, 8'd10, 8'hBF};                send_rec();
    // Copies: good, reaching ahead, out of window
    rec = {8'd4, 8'd0, 8'h60, 8'd4, 8'd0};     send_rec();
    rec = {8'd4, 8'd0, 8'h61, 8'd4, 8'd0};     send_rec();
    rec = {8'd4, 8'd0, 8'h60, 8'hFF, 8'hFF};   send_rec();
    // Gradients, rising and falling, wrapping
    rec = {8'd3, 8'd0, 8'hC7, 8'd200};         send_rec();
    rec = {8'd3, 8'd7, 8'hFF, 8'd3};           send_rec();
    rec = {8'd3, 8'd1, 8'hE5, 8'd250};         send_rec();
    // Overruns and an abandoned record
    rec = {8'd2, 8'd0, 8'h40};                 send_rec();
    rec = {8'd3, 8'd0, 8'h05, 8'd1};           send_rec();
    rec = {8'd10, 8'd0, 8'h03, 8'd1};          send_rec();
    // Pen running to its cap
    rec = {8'd0, 8'd255};
    repeat (12) rec = {rec, 8'h9F, 8'h11, 8'h22};
    rec[0] = 8'(rec.size() - 1);
    send_rec();
    random_bytes(3);

    write_width(0);   random_bytes(3);
    write_width(1);   random_bytes(3);
    write_width(511); random_bytes(3);
    write_width(100);
    calm = 1'b1;
    random_bytes(3);
    calm = 1'b0;
    write_width($urandom_range(1, 320));
    random_bytes(3);

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop if the decoder hangs
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
